### hdl/utf8_to_ucs2_stream_decoder_assert.svh
// assertion macros used by the decoder module u2u_dec
`ifndef UTF8_TO_UCS2_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_STREAM_DECODER_ASSERT_SVH

// property holds on every edge out of reset
`define U2U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds on the edge after the antecedent
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/u2u_pkg.sv
package u2u_pkg;

  typedef enum logic [0:0] {
    CfgRepl = 1'b0,
    CfgBom  = 1'b1
  } cfg_idx_t;

  localparam logic [15:0] ReplReset = 16'hFFFD;
  localparam logic [15:0] BomReset  = 16'hFEFF;

  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  localparam logic [7:0] BomB0 = 8'hEF;
  localparam logic [7:0] BomB1 = 8'hBB;
  localparam logic [7:0] BomB2 = 8'hBF;

  localparam logic [20:0] MinTwo   = 21'h00080;
  localparam logic [20:0] MinThree = 21'h00800;
  localparam logic [20:0] SurLo    = 21'h0D800;
  localparam logic [20:0] SurHi    = 21'h0DFFF;
  localparam logic [20:0] MinFour  = 21'h10000;
  localparam logic [20:0] MaxFour  = 21'h10FFFF;

  typedef struct packed {
    logic [15:0] code;
    logic        replaced;
    logic        is_bom;
  } res_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0) len = LenOne;
    else if (b[7:5] == 3'b110) len = LenTwo;
    else if (b[7:4] == 4'b1110) len = LenThree;
    else if (b[7:3] == 5'b11110) len = LenFour;
    else len = LenOne;
    return len;
  endfunction

endpackage

### hdl/utf8_to_ucs2_stream_decoder.sv
// a byte that closes a sequence gives its unit after the input register, then the decode
// into the result register
// throughput: one byte per cycle, held back only by a stalled result register
// reset: sequence state cleared, replacement and bom codes back to fffd and feff,
// no result pending
module utf8_to_ucs2_stream_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        byte_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       code_unit,
  output logic              replaced,
  output logic              is_bom,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  u2u_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data
);

  logic          ivalid;
  logic [7:0]    ibyte;
  logic          take;
  logic          has_res;
  logic          free;
  u2u_pkg::res_t res;
  u2u_pkg::res_t res_q;

  assign cfg_ready = 1'b1;

  // a beat moves on unless it makes a result the output cannot take
  assign take = ivalid && (!has_res || free);

  u2u_in u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .take     (take),
    .valid    (ivalid),
    .data     (ibyte)
  );

  u2u_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .fire      (take),
    .byte_in   (ibyte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .has_res   (has_res),
    .res       (res)
  );

  u2u_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && has_res),
    .res_in    (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign code_unit = res_q.code;
  assign replaced  = res_q.replaced;
  assign is_bom    = res_q.is_bom;

endmodule

### hdl/u2u_in.sv
module u2u_in (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       take,
  output logic       valid,
  output logic [7:0] data
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= byte_in;
    end
  end

endmodule

### hdl/u2u_dec.sv
`include "utf8_to_ucs2_stream_decoder_assert.svh"

module u2u_dec (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  input  logic              cfg_we,
  input  u2u_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              has_res,
  output u2u_pkg::res_t     res
);

  logic [15:0] repl_code;
  logic [15:0] bom_code;
  logic [1:0]  bl, bl_next;
  logic [2:0]  sl, sl_next;
  logic [20:0] acc, acc_next;
  logic        bm, bm_next;

  logic [2:0]  len;
  logic [20:0] acc_shift;
  logic [1:0]  bl_dec;
  logic        bm_n;
  logic        bad;
  logic        bom;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repl_code <= u2u_pkg::ReplReset;
      bom_code  <= u2u_pkg::BomReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        u2u_pkg::CfgRepl: repl_code <= cfg_data;
        u2u_pkg::CfgBom:  bom_code  <= cfg_data;
        default:          repl_code <= repl_code;
      endcase
    end
  end

  always_comb begin
    len       = u2u_pkg::lead_len(byte_in);
    acc_shift = {acc[14:0], byte_in[5:0]};
    bl_dec    = bl - 2'd1;

    priority if (sl == u2u_pkg::LenThree && bl == 2'd2) begin
      bm_n = bm && (byte_in == u2u_pkg::BomB1);
    end else if (sl == u2u_pkg::LenThree && bl == 2'd1) begin
      bm_n = bm && (byte_in == u2u_pkg::BomB2);
    end else begin
      bm_n = 1'b0;
    end

    bom = 1'b0;
    bad = 1'b0;
    priority if (sl == u2u_pkg::LenTwo) begin
      bad = acc_shift < u2u_pkg::MinTwo;
    end else if (sl == u2u_pkg::LenThree) begin
      bom = bm_n;
      bad = !bm_n && ((acc_shift < u2u_pkg::MinThree) ||
                      (acc_shift >= u2u_pkg::SurLo && acc_shift <= u2u_pkg::SurHi));
    end else begin
      bad = (acc_shift < u2u_pkg::MinFour) || (acc_shift > u2u_pkg::MaxFour);
    end

    bl_next      = bl;
    sl_next      = sl;
    acc_next     = acc;
    bm_next      = bm;
    has_res      = 1'b0;
    res.code     = 16'h0000;
    res.replaced = 1'b0;
    res.is_bom   = 1'b0;

    if (bl == 2'd0) begin
      if (len == u2u_pkg::LenOne) begin
        // single byte or stray byte passes as itself
        has_res  = 1'b1;
        res.code = {8'h00, byte_in};
      end else begin
        sl_next = len;
        bl_next = len[1:0] - 2'd1;
        bm_next = (byte_in == u2u_pkg::BomB0);
        priority if (len == u2u_pkg::LenTwo) begin
          acc_next = {16'h0000, byte_in[4:0]};
        end else if (len == u2u_pkg::LenThree) begin
          acc_next = {17'h00000, byte_in[3:0]};
        end else begin
          acc_next = {18'h00000, byte_in[2:0]};
        end
      end
    end else begin
      bl_next  = bl_dec;
      acc_next = acc_shift;
      bm_next  = bm_n;
      if (bl_dec == 2'd0) begin
        has_res      = 1'b1;
        res.replaced = bad;
        res.is_bom   = bom;
        res.code     = bom ? bom_code : (bad ? repl_code : acc_shift[15:0]);
        sl_next      = u2u_pkg::LenNone;
        acc_next     = 21'h000000;
        bm_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bl  <= 2'd0;
      sl  <= u2u_pkg::LenNone;
      acc <= 21'h000000;
      bm  <= 1'b0;
    end else if (fire) begin
      bl  <= bl_next;
      sl  <= sl_next;
      acc <= acc_next;
      bm  <= bm_next;
    end
  end

  `U2U_ASSERT(a_bom_result, !(has_res && res.is_bom) || (res.code == bom_code && !res.replaced), "bom result carries wrong code or flag")
  `U2U_ASSERT(a_len_pending, (bl == 2'd0) || (sl >= u2u_pkg::LenTwo), "continuation pending without a multi-byte length")
  `U2U_ASSERT_NEXT(a_seq_done, fire && bl == 2'd1, bl == 2'd0 && sl == u2u_pkg::LenNone, "sequence not closed after last beat")

endmodule

### hdl/u2u_out.sv
module u2u_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  u2u_pkg::res_t res_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output u2u_pkg::res_t res_out
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

### tb/sv/utf8_unit_checker.sv
module utf8_unit_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        byte_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       code_unit,
  input  logic              replaced,
  input  logic              is_bom,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  u2u_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data,
  output int                fail_count,
  output int                pending
);
  import u2u_pkg::*;

  res_t        expected_units[$];
  logic [1:0]  left_cnt;
  logic [2:0]  seq_len;
  logic [20:0] acc;
  logic        bom_seen;
  logic [15:0] repl_code;
  logic [15:0] bom_val;
  int          mismatches;

  function automatic logic [2:0] byte_len(input logic [7:0] b);
    logic [2:0] len;
    casez (b)
      8'b0???????: len = LenOne;
      8'b110?????: len = LenTwo;
      8'b1110????: len = LenThree;
      8'b11110???: len = LenFour;
      default:     len = LenOne;
    endcase
    return len;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    res_t       r;
    logic [2:0] len;
    logic       bad;
    logic       bom;
    len = byte_len(b);
    bad = 1'b0;
    bom = 1'b0;
    if (left_cnt == 2'd0) begin
      if (len == LenOne) begin
        r.code = {8'h00, b};
        r.replaced = 1'b0;
        r.is_bom = 1'b0;
        expected_units.push_back(r);
        return;
      end
      seq_len = len;
      left_cnt = 2'(len - 3'd1);
      case (len)
        LenTwo:   acc = {16'h0, b[4:0]};
        LenThree: acc = {17'h0, b[3:0]};
        default:  acc = {18'h0, b[2:0]};
      endcase
      bom_seen = (b == BomB0);
      return;
    end
    // continuation tags are never checked
    if (seq_len == LenThree && left_cnt == 2'd2) begin
      if (b != BomB1) bom_seen = 1'b0;
    end else if (seq_len == LenThree && left_cnt == 2'd1) begin
      if (b != BomB2) bom_seen = 1'b0;
    end else begin
      bom_seen = 1'b0;
    end
    acc = {acc[14:0], b[5:0]};
    left_cnt = left_cnt - 2'd1;
    if (left_cnt != 2'd0) return;
    if (seq_len == LenTwo) begin
      bad = (acc < MinTwo);
    end else if (seq_len == LenThree) begin
      if (bom_seen) bom = 1'b1;
      else if (acc < MinThree) bad = 1'b1;
      else if (acc >= SurLo && acc <= SurHi) bad = 1'b1;
    end else begin
      bad = (acc < MinFour) || (acc > MaxFour);
    end
    r.code = bom ? bom_val : (bad ? repl_code : acc[15:0]);
    r.replaced = bad;
    r.is_bom = bom;
    expected_units.push_back(r);
    seq_len = LenNone;
    acc = '0;
    bom_seen = 1'b0;
  endtask

  task automatic check_unit();
    res_t want;
    if (expected_units.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected unit: code %h replaced %b is_bom %b",
                 code_unit, replaced, is_bom);
      return;
    end
    want = expected_units.pop_front();
    if (want.code !== code_unit || want.replaced !== replaced || want.is_bom !== is_bom) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unit mismatch: want %h/%b/%b got %h/%b/%b (code/replaced/is_bom)",
                 want.code, want.replaced, want.is_bom, code_unit, replaced, is_bom);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_units.delete();
      left_cnt = 2'd0;
      seq_len = LenNone;
      acc = '0;
      bom_seen = 1'b0;
      repl_code = ReplReset;
      bom_val = BomReset;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgRepl: repl_code = cfg_data;
          CfgBom:  bom_val = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_unit();
      if (in_valid && in_ready) decode_byte(byte_in);
    end
    fail_count <= mismatches;
    pending <= expected_units.size();
  end
endmodule

### tb/sv/utf8_to_ucs2_stream_decoder_tb.sv
module utf8_to_ucs2_stream_decoder_tb;
  import u2u_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseBytes = 180;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        replaced;
  logic        is_bom;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CfgRepl;
  logic [15:0] cfg_data = 16'h0000;

  int fail_count;
  int pending;
  int src_idle = 0;
  int sink_stall = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  logic [7:0] directed_bytes [26] = '{
    8'h00, 8'h80, 8'hFF, 8'hC2, 8'h80, 8'hC1, 8'hBF, 8'hEF, 8'hBB, 8'hBF,
    8'hED, 8'hA0, 8'h80, 8'hE0, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hF4, 8'h90, 8'h80, 8'h80, 8'hC3, 8'hE9
  };

  always #2 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= sink_stall);

  utf8_to_ucs2_stream_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .byte_in   (byte_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .replaced  (replaced),
    .is_bom    (is_bom),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  utf8_unit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .replaced   (replaced),
    .is_bom     (is_bom),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // leaves valid high on return, caller lowers it
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic send_random_char();
    int          kind;
    int          n;
    logic [20:0] cp;
    kind = $urandom_range(99);
    if (kind < 15) begin
      push_byte(8'($urandom_range(255)));
    end else if (kind < 22) begin
      // lead followed by arbitrary bytes, leads included
      n = $urandom_range(4, 2);
      case (n)
        2:       push_byte({3'b110, 5'($urandom)});
        3:       push_byte({4'b1110, 4'($urandom)});
        default: push_byte({5'b11110, 3'($urandom)});
      endcase
      repeat (n - 1) push_byte(8'($urandom_range(255)));
    end else if (kind < 25) begin
      push_byte(BomB0);
      push_byte(BomB1);
      push_byte(BomB2);
    end else begin
      n = $urandom_range(4, 1);
      case (n)
        1: begin
          push_byte(8'($urandom_range(127)));
        end
        2: begin
          cp = 21'($urandom_range(16'h7FF));
          push_byte({3'b110, cp[10:6]});
          push_byte({2'b10, cp[5:0]});
        end
        3: begin
          cp = 21'($urandom_range(16'hFFFF));
          push_byte({4'b1110, cp[15:12]});
          push_byte({2'b10, cp[11:6]});
          push_byte({2'b10, cp[5:0]});
        end
        default: begin
          if ($urandom_range(1) == 0) cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
          else cp = 21'($urandom_range(32'h1FFFFF));
          push_byte({5'b11110, cp[20:18]});
          push_byte({2'b10, cp[17:12]});
          push_byte({2'b10, cp[11:6]});
          push_byte({2'b10, cp[5:0]});
        end
      endcase
    end
  endtask

  initial begin
    int          idle_set  [5];
    int          stall_set [5];
    logic [15:0] repl_set  [5];
    logic [15:0] bom_set   [5];
    idle_set  = '{0, 48, 0, 36, 0};
    stall_set = '{0, 0, 48, 36, 0};
    repl_set = '{16'hFFFD, 16'h0000, 16'hFFFF, 16'($urandom), 16'hFFFD};
    bom_set  = '{16'hFEFF, 16'hFFFF, 16'h0000, 16'($urandom), 16'hFEFF};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
    for (int p = 0; p < 5; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_write(CfgRepl, repl_set[p]);
        cfg_write(CfgBom, bom_set[p]);
        cfg_valid <= 1'b0;
        @(negedge clk);
      end
      src_idle = idle_set[p];
      sink_stall = stall_set[p];
      while (bytes_sent < PhaseBytes * (p + 1) + 26) begin
        send_random_char();
        if ($urandom_range(49) == 0) wait_drained();
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
